/* hdl/adbs_pkg.sv */
// Shared types, constants and codes for the APNG dispose bounding-box selector.
package adbs_pkg;

	localparam int PIX_W     = 32;
	localparam int COORD_W   = 12;
	localparam int DIM_W     = 13;
	localparam int AREA_W    = 2 * DIM_W;
	localparam int BPP_W     = 3;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_BOX   = 3;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_BYTES  = 4;
	localparam int BG_BYTES   = 4;

	// box slots
	localparam int BOX_NONE = 0;
	localparam int BOX_PREV = 1;
	localparam int BOX_BG   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RECT_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RECT_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RECT_W    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RECT_H    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME  = 3'd7;

	typedef enum logic [1:0] {
		OP_NONE       = 2'd0,
		OP_BACKGROUND = 2'd1,
		OP_PREVIOUS   = 2'd2
	} disp_op_t;

	// decoded configuration
	typedef struct packed {
		logic [COORD_W-1:0] last_col;
		logic [COORD_W-1:0] last_row;
		logic [PIX_W-1:0]   byte_mask;
		logic               bg_mode;
		logic [COORD_W-1:0] bg_x;
		logic [COORD_W-1:0] bg_y;
		logic [DIM_W-1:0]   bg_w;
		logic [DIM_W-1:0]   bg_h;
		logic               first_frame;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] min_col;
		logic [COORD_W-1:0] max_col;
		logic [COORD_W-1:0] min_row;
		logic [COORD_W-1:0] max_row;
		logic               found;
	} box_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [AREA_W-1:0]  area;
		logic               found;
	} area_box_t;

endpackage

/* hdl/adbs_cfg_regs.sv */
// Configuration registers and their decoded, range-clamped view.
module adbs_cfg_regs
	import adbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	localparam logic [DIM_W-1:0] MAX_W_C  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_C  = DIM_W'(MAX_HEIGHT);
	localparam logic [BPP_W-1:0] MAX_B_C  = BPP_W'(MAX_BYTES);
	localparam logic [BPP_W-1:0] BG_B_C   = BPP_W'(BG_BYTES);

	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	logic [BPP_W-1:0]   bytes_per_pixel_q;
	logic [COORD_W-1:0] bg_rect_x_q;
	logic [COORD_W-1:0] bg_rect_y_q;
	logic [DIM_W-1:0]   bg_rect_w_q;
	logic [DIM_W-1:0]   bg_rect_h_q;
	logic               first_frame_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [BPP_W-1:0] nb_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= DIM_W'(1);
			frame_height_q    <= DIM_W'(1);
			bytes_per_pixel_q <= BPP_W'(4);
			bg_rect_x_q       <= '0;
			bg_rect_y_q       <= '0;
			bg_rect_w_q       <= DIM_W'(1);
			bg_rect_h_q       <= DIM_W'(1);
			first_frame_q     <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q     <= cfg_wdata;
				CFG_FRAME_HEIGHT: frame_height_q    <= cfg_wdata;
				CFG_BYTES_PER_PX: bytes_per_pixel_q <= cfg_wdata[BPP_W-1:0];
				CFG_BG_RECT_X:    bg_rect_x_q       <= cfg_wdata[COORD_W-1:0];
				CFG_BG_RECT_Y:    bg_rect_y_q       <= cfg_wdata[COORD_W-1:0];
				CFG_BG_RECT_W:    bg_rect_w_q       <= cfg_wdata;
				CFG_BG_RECT_H:    bg_rect_h_q       <= cfg_wdata;
				CFG_FIRST_FRAME:  first_frame_q     <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		// zero acts as one, oversize acts as the maximum
		if (frame_width_q == '0)
			w_eff = DIM_W'(1);
		else if (frame_width_q > MAX_W_C)
			w_eff = MAX_W_C;
		else
			w_eff = frame_width_q;

		if (frame_height_q == '0)
			h_eff = DIM_W'(1);
		else if (frame_height_q > MAX_H_C)
			h_eff = MAX_H_C;
		else
			h_eff = frame_height_q;

		if (bytes_per_pixel_q == '0)
			nb_eff = BPP_W'(1);
		else if (bytes_per_pixel_q > MAX_B_C)
			nb_eff = MAX_B_C;
		else
			nb_eff = bytes_per_pixel_q;

		cfg.last_col = COORD_W'(w_eff - DIM_W'(1));
		cfg.last_row = COORD_W'(h_eff - DIM_W'(1));

		unique case (nb_eff)
			BPP_W'(1): cfg.byte_mask = 32'h0000_00FF;
			BPP_W'(2): cfg.byte_mask = 32'h0000_FFFF;
			BPP_W'(3): cfg.byte_mask = 32'h00FF_FFFF;
			default:   cfg.byte_mask = 32'hFFFF_FFFF;
		endcase

		cfg.bg_mode     = (nb_eff == BG_B_C);
		cfg.bg_x        = bg_rect_x_q;
		cfg.bg_y        = bg_rect_y_q;
		cfg.bg_w        = bg_rect_w_q;
		cfg.bg_h        = bg_rect_h_q;
		cfg.first_frame = first_frame_q;
	end

endmodule

/* hdl/adbs_box_tracker.sv */
// Pixel input register, raster position and the three changed-pixel boxes.
module adbs_box_tracker
	import adbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] cur_pixel,
	input  logic [PIX_W-1:0] next_pixel,
	input  logic [PIX_W-1:0] prev_pixel,
	output logic             snap_valid,
	input  logic             snap_ready,
	output box_t             snap_box [NUM_BOX]
);

	logic             v_s1;
	logic [PIX_W-1:0] cur_s1;
	logic [PIX_W-1:0] next_s1;
	logic [PIX_W-1:0] prev_s1;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	box_t               box_q [NUM_BOX];

	logic   snap_v_s2;
	box_t   snap_s2 [NUM_BOX];

	logic [PIX_W-1:0]   cur_m, nxt_m, prv_m;
	logic [COORD_W+1:0] rect_x_end, rect_y_end;
	logic               in_rect;
	logic [NUM_BOX-1:0] hit;
	box_t               box_d [NUM_BOX];
	logic               last_col, last_row, last_pix;
	logic               snap_free, s1_go;

	always_comb begin
		cur_m = cur_s1 & cfg.byte_mask;
		nxt_m = next_s1 & cfg.byte_mask;
		prv_m = prev_s1 & cfg.byte_mask;

		rect_x_end = {2'b00, cfg.bg_x} + {1'b0, cfg.bg_w};
		rect_y_end = {2'b00, cfg.bg_y} + {1'b0, cfg.bg_h};
		in_rect = (col_q >= cfg.bg_x) && ({2'b00, col_q} < rect_x_end) &&
		          (row_q >= cfg.bg_y) && ({2'b00, row_q} < rect_y_end);

		hit[BOX_NONE] = (cur_m != nxt_m);
		hit[BOX_PREV] = (prv_m != nxt_m);
		hit[BOX_BG]   = in_rect ? (nxt_m != '0) : (cur_m != nxt_m);

		for (int k = 0; k < NUM_BOX; k++) begin
			box_d[k] = box_q[k];
			if (hit[k]) begin
				if (!box_q[k].found) begin
					box_d[k].found   = 1'b1;
					box_d[k].min_col = col_q;
					box_d[k].max_col = col_q;
					box_d[k].min_row = row_q;
					box_d[k].max_row = row_q;
				end else begin
					if (col_q < box_q[k].min_col) box_d[k].min_col = col_q;
					if (col_q > box_q[k].max_col) box_d[k].max_col = col_q;
					if (row_q < box_q[k].min_row) box_d[k].min_row = row_q;
					if (row_q > box_q[k].max_row) box_d[k].max_row = row_q;
				end
			end
		end

		// a shrunk size clips the position to the new last column or row
		last_col = (col_q >= cfg.last_col);
		last_row = (row_q >= cfg.last_row);
		last_pix = last_col && last_row;

		snap_free = !snap_v_s2 || snap_ready;
		s1_go     = v_s1 && (!last_pix || snap_free);
		in_ready  = !v_s1 || s1_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_s1  <= cur_pixel;
			next_s1 <= next_pixel;
			prev_s1 <= prev_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < NUM_BOX; k++) begin
				box_q[k] <= '{min_col: '1, max_col: '0, min_row: '1, max_row: '0,
				              found: 1'b0};
			end
		end else if (s1_go) begin
			if (last_pix) begin
				col_q <= '0;
				row_q <= '0;
				for (int k = 0; k < NUM_BOX; k++) begin
					box_q[k] <= '{min_col: '1, max_col: '0, min_row: '1, max_row: '0,
					              found: 1'b0};
				end
			end else begin
				for (int k = 0; k < NUM_BOX; k++) begin
					box_q[k] <= box_d[k];
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s2 <= 1'b0;
		end else if (snap_free) begin
			snap_v_s2 <= v_s1 && last_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_free && v_s1 && last_pix) begin
			for (int k = 0; k < NUM_BOX; k++) begin
				snap_s2[k] <= box_d[k];
			end
		end
	end

	assign snap_valid = snap_v_s2;
	always_comb begin
		for (int k = 0; k < NUM_BOX; k++) begin
			snap_box[k] = snap_s2[k];
		end
	end

endmodule

/* hdl/adbs_area_calc.sv */
// Box sizes and areas for a finished frame, one multiplier per box.
module adbs_area_calc
	import adbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      snap_valid,
	output logic      snap_ready,
	input  box_t      snap_box [NUM_BOX],
	output logic      area_valid,
	input  logic      area_ready,
	output area_box_t area_box [NUM_BOX]
);

	logic      v_s3;
	area_box_t box_s3 [NUM_BOX];
	area_box_t box_d  [NUM_BOX];

	always_comb begin
		for (int k = 0; k < NUM_BOX; k++) begin
			box_d[k].x     = snap_box[k].min_col;
			box_d[k].y     = snap_box[k].min_row;
			box_d[k].w     = {1'b0, snap_box[k].max_col} - {1'b0, snap_box[k].min_col}
			                 + DIM_W'(1);
			box_d[k].h     = {1'b0, snap_box[k].max_row} - {1'b0, snap_box[k].min_row}
			                 + DIM_W'(1);
			box_d[k].area  = box_d[k].w * box_d[k].h;
			box_d[k].found = snap_box[k].found;
		end
		snap_ready = !v_s3 || area_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (snap_ready) begin
			v_s3 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			for (int k = 0; k < NUM_BOX; k++) begin
				box_s3[k] <= box_d[k];
			end
		end
	end

	assign area_valid = v_s3;
	always_comb begin
		for (int k = 0; k < NUM_BOX; k++) begin
			area_box[k] = box_s3[k];
		end
	end

endmodule

/* hdl/adbs_decide.sv */
// Dispose-op choice from the three boxes, into the result register.
module adbs_decide
	import adbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               area_valid,
	output logic               area_ready,
	input  area_box_t          area_box [NUM_BOX],
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         disp_op,
	output logic [COORD_W-1:0] box_x,
	output logic [COORD_W-1:0] box_y,
	output logic [DIM_W-1:0]   box_w,
	output logic [DIM_W-1:0]   box_h
);

	logic               v_s4;
	disp_op_t           op_s4;
	logic [COORD_W-1:0] x_s4, y_s4;
	logic [DIM_W-1:0]   w_s4, h_s4;

	logic        lt10, lt20, lt21;
	disp_op_t    op_d;
	logic        empty_d;
	area_box_t   sel_d;

	always_comb begin
		// pairwise compares in parallel, selection afterwards
		lt10 = area_box[BOX_PREV].area < area_box[BOX_NONE].area;
		lt20 = area_box[BOX_BG].area   < area_box[BOX_NONE].area;
		lt21 = area_box[BOX_BG].area   < area_box[BOX_PREV].area;

		op_d    = OP_NONE;
		empty_d = 1'b0;
		sel_d   = area_box[BOX_NONE];

		priority if (!area_box[BOX_NONE].found) begin
			op_d    = OP_NONE;
			empty_d = 1'b1;
		end else if (cfg.first_frame) begin
			op_d  = OP_NONE;
			sel_d = area_box[BOX_NONE];
		end else if (!area_box[BOX_PREV].found) begin
			op_d    = OP_PREVIOUS;
			empty_d = 1'b1;
		end else if (cfg.bg_mode && !area_box[BOX_BG].found) begin
			op_d    = OP_BACKGROUND;
			empty_d = 1'b1;
		end else if (cfg.bg_mode && (lt10 ? lt21 : lt20)) begin
			op_d  = OP_BACKGROUND;
			sel_d = area_box[BOX_BG];
		end else if (lt10) begin
			op_d  = OP_PREVIOUS;
			sel_d = area_box[BOX_PREV];
		end else begin
			op_d  = OP_NONE;
			sel_d = area_box[BOX_NONE];
		end

		area_ready = !v_s4 || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (area_ready) begin
			v_s4 <= area_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (area_ready && area_valid) begin
			op_s4 <= op_d;
			if (empty_d) begin
				x_s4 <= '0;
				y_s4 <= '0;
				w_s4 <= DIM_W'(1);
				h_s4 <= DIM_W'(1);
			end else begin
				x_s4 <= sel_d.x;
				y_s4 <= sel_d.y;
				w_s4 <= sel_d.w;
				h_s4 <= sel_d.h;
			end
		end
	end

	assign out_valid = v_s4;
	assign disp_op   = op_s4;
	assign box_x     = x_s4;
	assign box_y     = y_s4;
	assign box_w     = w_s4;
	assign box_h     = h_s4;

endmodule

/* hdl/apng_dispose_bbox_selector.sv */
// Top level of the APNG dispose-op bounding-box selector.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  pixels   | in_valid / in_ready   | cur_pixel, next_pixel, prev_pixel
//  result   | out_valid / out_ready | disp_op, box_x, box_y, box_w, box_h
//  config   | cfg_wr_en             | cfg_index, cfg_wdata
//
// One pixel triple per clock, except that a frame's last pixel waits while the
// snapshot stage is full. A frame result then passes through the input
// register, box snapshot, area multiply and decision into the result register.
// Reset brings the raster position to 0,0 and all boxes to empty; nothing
// needs clearing afterwards. A stalled result holds the decision pipe, and
// pixels keep flowing until another frame end reaches a full snapshot stage.
module apng_dispose_bbox_selector
	import adbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// pixel stream, raster order
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     cur_pixel,
	input  logic [PIX_W-1:0]     next_pixel,
	input  logic [PIX_W-1:0]     prev_pixel,
	// one result per frame
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           disp_op,
	output logic [COORD_W-1:0]   box_x,
	output logic [COORD_W-1:0]   box_y,
	output logic [DIM_W-1:0]     box_w,
	output logic [DIM_W-1:0]     box_h
);

	cfg_t      cfg;
	logic      snap_valid, snap_ready;
	box_t      snap_box [NUM_BOX];
	logic      area_valid, area_ready;
	area_box_t area_box [NUM_BOX];

	// registers plus clamped sizes, byte mask and background-mode flag
	adbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// per-pixel compares and min/max box updates; snapshot at frame end
	adbs_box_tracker u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cur_pixel  (cur_pixel),
		.next_pixel (next_pixel),
		.prev_pixel (prev_pixel),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap_box   (snap_box)
	);

	// widths, heights and 13x13 area products
	adbs_area_calc u_area (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap_box   (snap_box),
		.area_valid (area_valid),
		.area_ready (area_ready),
		.area_box   (area_box)
	);

	// first frame picks none, else empty box wins at once, else strictly smaller area; result register
	adbs_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.area_valid (area_valid),
		.area_ready (area_ready),
		.area_box   (area_box),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.disp_op    (disp_op),
		.box_x      (box_x),
		.box_y      (box_y),
		.box_w      (box_w),
		.box_h      (box_h)
	);

endmodule
